// File: design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types for the key sorter
// Item record layout, the sequencer state encoding and the signed key compare.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KeyW = 32;
  localparam int TagW = 31;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] first_tag;
    logic [TagW-1:0] second_tag;
  } rec_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_POP,
    ST_PIVRD,
    ST_SCAN,
    ST_SWAPW,
    ST_PIVSW,
    ST_PIVSW2,
    ST_PUSH,
    ST_OUTRD,
    ST_OUT
  } state_t;

  // Signed keys compared as unsigned after flipping the sign bit.
  function automatic logic key_le(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    logic [KeyW-1:0] ua;
    logic [KeyW-1:0] ub;
    ua = a ^ {1'b1, {(KeyW-1){1'b0}}};
    ub = b ^ {1'b1, {(KeyW-1){1'b0}}};
    return ua <= ub;
  endfunction

endpackage

// File: design/skt_mem.sv
// ----------------------------------------------------------------------------
// skt_mem: item store
// Record memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module skt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  skt_pkg::rec_t      wdata,
  input  logic [AW-1:0]      raddr_a,
  input  logic [AW-1:0]      raddr_b,
  output skt_pkg::rec_t      rdata_a,
  output skt_pkg::rec_t      rdata_b
);

  skt_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/sort_keys_with_two_index_tags_unit.sv
// ----------------------------------------------------------------------------
// sort_keys_with_two_index_tags_unit: batch quicksort of keyed items
// Loads items, sorts them by signed key with Lomuto quicksort, emits them.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (key and two tags) are taken one per cycle while loading.
//   The item with in_last set closes the batch; items beyond MAX_ITEMS are
//   dropped and every result of that batch carries out_overflow.
//   The batch is then sorted in place in a record memory with one write
//   and two read ports; ranges sit on a small stack memory. Each range is
//   partitioned by a pivot read, a scan of its elements with a swap for
//   each one that belongs left, a pivot swap and pushes of its child
//   ranges; then the next range is popped from the stack. The sorted
//   items leave in key order, the final one with out_final_res set;
//   each is read only after the one before it is in the output
//   register. in_ready is low from the end of a batch until its last
//   result is in the output register. A stalled receiver holds the
//   output register and the sequencer waits. Reset empties the batch;
//   no clearing pass.
// ----------------------------------------------------------------------------
module sort_keys_with_two_index_tags_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_key,
  input  logic [30:0] in_first_tag,
  input  logic [30:0] in_second_tag,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sorted_key,
  output logic [30:0] out_sorted_first_tag,
  output logic [30:0] out_sorted_second_tag,
  output logic        out_final_res,
  output logic        out_overflow
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SD = MAX_ITEMS + 2;
  localparam int SW = $clog2(SD + 1);
  localparam int SAW = $clog2(SD);
  localparam int KeyW_L = skt_pkg::KeyW;

  skt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt, slot_r, slot_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic [1:0]    npush_r, npush_nxt;
  logic [AW-1:0] psh0_r, psh0_nxt, psh1_r, psh1_nxt, psh2_r, psh2_nxt, psh3_r, psh3_nxt;
  logic [1:0]    pidx_r, pidx_nxt;
  logic          popph_r, popph_nxt;
  logic [KeyW_L-1:0] piv_r, piv_nxt;
  skt_pkg::rec_t hold_r, hold_nxt;
  logic          ov_r, ov_nxt;
  skt_pkg::rec_t orec_r, orec_nxt;
  logic          ofin_r, ofin_nxt;

  // memory ports
  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  skt_pkg::rec_t wdata, rda, rdb;

  skt_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
  );

  // range stack
  logic [AW-1:0] stk [SD];
  logic          s_we;
  logic [SAW-1:0] s_wa, s_ra;
  logic [AW-1:0] s_wd, s_rd;

  always_ff @(posedge clk) begin
    if (s_we) begin
      stk[s_wa] <= s_wd;
    end
    s_rd <= stk[s_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skt_pkg::ST_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
      sp_r    <= '0;
      popph_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      sp_r    <= sp_nxt;
      popph_r <= popph_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; j_r <= j_nxt; slot_r <= slot_nxt;
    npush_r <= npush_nxt; pidx_r <= pidx_nxt;
    psh0_r <= psh0_nxt; psh1_r <= psh1_nxt; psh2_r <= psh2_nxt; psh3_r <= psh3_nxt;
    piv_r <= piv_nxt; hold_r <= hold_nxt; orec_r <= orec_nxt; ofin_r <= ofin_nxt;
  end

  logic out_free;
  assign out_free = !ov_r || out_ready;

  always_comb begin
    logic [AW-1:0] pv;
    logic [AW-1:0] cur;
    logic          push_l, push_r;
    pv        = '0;
    cur       = '0;
    push_l    = 1'b0;
    push_r    = 1'b0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    lo_nxt = lo_r; hi_nxt = hi_r; j_nxt = j_r; slot_nxt = slot_r;
    sp_nxt = sp_r; npush_nxt = npush_r; pidx_nxt = pidx_r; popph_nxt = popph_r;
    psh0_nxt = psh0_r; psh1_nxt = psh1_r; psh2_nxt = psh2_r; psh3_nxt = psh3_r;
    piv_nxt = piv_r; hold_nxt = hold_r; orec_nxt = orec_r; ofin_nxt = ofin_r;
    ov_nxt  = ov_r && !out_ready;
    in_ready = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0; ra = '0; rb = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;

    case (state_r)
      skt_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            we    = 1'b1;
            waddr = cnt_r[AW-1:0];
            wdata = '{key: in_key, first_tag: in_first_tag, second_tag: in_second_tag};
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            if (cnt_nxt >= CW'(2)) begin
              // Start with the whole batch as the first range; the stack starts empty.
              lo_nxt = '0;
              hi_nxt = AW'(cnt_nxt - 1'b1);
              sp_nxt = '0;
              state_nxt = skt_pkg::ST_PIVRD;
            end else begin
              j_nxt = '0;
              state_nxt = skt_pkg::ST_OUTRD;
            end
          end
        end
      end
      skt_pkg::ST_POP: begin
        // Read hi, then lo; the stack read is registered.
        if (!popph_r) begin
          if (sp_r < SW'(2)) begin
            j_nxt = '0;
            state_nxt = skt_pkg::ST_OUTRD;
          end else begin
            s_ra = SAW'(sp_r - 1'b1);
            popph_nxt = 1'b1;
          end
        end else begin
          if (pidx_r == 2'd0) begin
            hi_nxt = s_rd;
            s_ra = SAW'(sp_r - 2'd2);
            pidx_nxt = 2'd1;
          end else begin
            lo_nxt = s_rd;
            sp_nxt = sp_r - 2'd2;
            pidx_nxt = 2'd0;
            popph_nxt = 1'b0;
            state_nxt = (s_rd < hi_r) ? skt_pkg::ST_PIVRD : skt_pkg::ST_POP;
          end
        end
      end
      skt_pkg::ST_PIVRD: begin
        // Read pivot (port b) and first scan element (port a).
        rb = hi_r;
        ra = lo_r;
        j_nxt = lo_r;
        slot_nxt = lo_r;
        state_nxt = skt_pkg::ST_SCAN;
        popph_nxt = 1'b0;
      end
      skt_pkg::ST_SCAN: begin
        if (j_r == lo_r && !popph_r) begin
          piv_nxt = rdb.key;
        end
        popph_nxt = 1'b1;
        cur = j_r;
        if (j_r == hi_r) begin
          // Scan done: swap pivot into slot.
          ra = slot_r;
          rb = hi_r;
          popph_nxt = 1'b0;
          state_nxt = skt_pkg::ST_PIVSW;
        end else if (skt_pkg::key_le(rda.key,
                     (j_r == lo_r && !popph_r) ? rdb.key : piv_r)) begin
          // Element at j belongs left: read slot, then swap.
          hold_nxt = rda;
          ra = slot_r;
          state_nxt = skt_pkg::ST_SWAPW;
        end else begin
          j_nxt = cur + 1'b1;
          ra = AW'(cur + 1'b1);
        end
      end
      skt_pkg::ST_SWAPW: begin
        // Memory has one write port: write j now, slot next cycle via hold.
        we = 1'b1;
        waddr = j_r;
        wdata = rda;
        hold_nxt = hold_r;
        state_nxt = skt_pkg::ST_PIVSW2;
        pidx_nxt = 2'd1;
      end
      skt_pkg::ST_PIVSW2: begin
        we = 1'b1;
        waddr = slot_r;
        wdata = hold_r;
        if (pidx_r == 2'd1) begin
          slot_nxt = slot_r + 1'b1;
          j_nxt = j_r + 1'b1;
          ra = AW'(j_r + 1'b1);
          pidx_nxt = 2'd0;
          state_nxt = skt_pkg::ST_SCAN;
        end else begin
          // Pivot placed; queue the child ranges, left first.
          pv = slot_r;
          push_l = (pv > lo_r + AW'(1)) && (pv > lo_r);
          push_r = ({1'b0, pv} + 1'b1 < {1'b0, hi_r});
          npush_nxt = 2'd0;
          pidx_nxt  = 2'd0;
          if (push_l && push_r) begin
            psh0_nxt = lo_r; psh1_nxt = pv - 1'b1;
            psh2_nxt = pv + 1'b1; psh3_nxt = hi_r;
            npush_nxt = 2'd2;
          end else if (push_l) begin
            psh0_nxt = lo_r; psh1_nxt = pv - 1'b1; npush_nxt = 2'd1;
          end else if (push_r) begin
            psh0_nxt = pv + 1'b1; psh1_nxt = hi_r; npush_nxt = 2'd1;
          end
          state_nxt = skt_pkg::ST_PUSH;
        end
      end
      skt_pkg::ST_PIVSW: begin
        // rda = slot, rdb = pivot at hi.
        we = 1'b1;
        waddr = hi_r;
        wdata = rda;
        hold_nxt = rdb;
        pidx_nxt = 2'd0;
        state_nxt = skt_pkg::ST_PIVSW2;
      end
      skt_pkg::ST_PUSH: begin
        if (npush_r == 2'd0 && pidx_r == 2'd0) begin
          state_nxt = skt_pkg::ST_POP;
        end else begin
          s_we = 1'b1;
          s_wa = SAW'(sp_r);
          case (pidx_r)
            2'd0:    s_wd = psh0_r;
            2'd1:    s_wd = psh1_r;
            2'd2:    s_wd = psh2_r;
            default: s_wd = psh3_r;
          endcase
          sp_nxt = sp_r + 1'b1;
          pidx_nxt = pidx_r + 1'b1;
          if ({1'b0, pidx_r} + 3'd1 == {npush_r, 1'b0}) begin
            pidx_nxt = 2'd0;
            npush_nxt = 2'd0;
            state_nxt = skt_pkg::ST_POP;
          end
        end
      end
      skt_pkg::ST_OUTRD: begin
        ra = j_r;
        state_nxt = skt_pkg::ST_OUT;
      end
      skt_pkg::ST_OUT: begin
        ra = j_r;
        if (out_free) begin
          ov_nxt   = 1'b1;
          orec_nxt = rda;
          ofin_nxt = ({1'b0, j_r} + 1'b1 == {1'b0, cnt_r});
          if ({1'b0, j_r} + 1'b1 == {1'b0, cnt_r}) begin
            cnt_nxt = '0;
            drop_nxt = 1'b0;
            state_nxt = skt_pkg::ST_LOAD;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = skt_pkg::ST_OUTRD;
          end
        end
      end
      default: state_nxt = skt_pkg::ST_LOAD;
    endcase
  end

  // Overflow flag is sampled with each result; the drop flag behind it is cleared once the batch ends.
  logic oflow_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oflow_r <= 1'b0;
    end else if (state_r == skt_pkg::ST_OUT && out_free) begin
      oflow_r <= drop_r;
    end
  end

  assign out_valid             = ov_r;
  assign out_sorted_key        = orec_r.key;
  assign out_sorted_first_tag  = orec_r.first_tag;
  assign out_sorted_second_tag = orec_r.second_tag;
  assign out_final_res         = ofin_r;
  assign out_overflow          = oflow_r;

endmodule
